// ===== rtl/nlp_pkg.sv =====
// Shared types and constants for the numeric literal parser.
// Holds the character codes and the character class record.
// No dependencies.
package nlp_pkg;

    localparam int unsigned CharW  = 8;
    localparam int unsigned ValueW = 32;
    localparam int unsigned CountW = 8;
    localparam int unsigned DigitW = 4;

    localparam logic [CharW-1:0] ChMinus  = 8'h2D; // '-'
    localparam logic [CharW-1:0] ChDollar = 8'h24; // '$'
    localparam logic [CharW-1:0] ChPct    = 8'h25; // '%'
    localparam logic [CharW-1:0] ChLowX   = 8'h78; // 'x'
    localparam logic [CharW-1:0] Ch0      = 8'h30;
    localparam logic [CharW-1:0] Ch1      = 8'h31;
    localparam logic [CharW-1:0] Ch9      = 8'h39;
    localparam logic [CharW-1:0] ChLowA   = 8'h61;
    localparam logic [CharW-1:0] ChLowF   = 8'h66;
    localparam logic [CharW-1:0] ChUpA    = 8'h41;
    localparam logic [CharW-1:0] ChUpF    = 8'h46;

    // Classification of one input character
    typedef struct packed {
        logic              is_minus;
        logic              is_hex_pfx;
        logic              is_bin_pfx;
        logic              bin_ok;
        logic              dec_ok;
        logic              hex_ok;
        logic [DigitW-1:0] digit;
    } t_char_class;

endpackage

// ===== rtl/nlp_char_dec.sv =====
// Character classifier for the numeric literal parser.
// Flags prefix and sign codes and decodes the digit value for each radix.
// Depends on nlp_pkg.
module nlp_char_dec
    import nlp_pkg::*;
(
    input  logic [CharW-1:0] i_char,
    output t_char_class      o_class
);

    logic              is_dec;
    logic              is_low;
    logic              is_up;
    logic [CharW-1:0]  off;

    always_comb begin
        is_dec = (i_char >= Ch0)    && (i_char <= Ch9);
        is_low = (i_char >= ChLowA) && (i_char <= ChLowF);
        is_up  = (i_char >= ChUpA)  && (i_char <= ChUpF);

        if (is_dec) begin
            off = i_char - Ch0;
        end else if (is_low) begin
            off = i_char - ChLowA + 8'd10;
        end else if (is_up) begin
            off = i_char - ChUpA + 8'd10;
        end else begin
            off = '0;
        end

        o_class.is_minus   = (i_char == ChMinus);
        o_class.is_hex_pfx = (i_char == ChLowX) || (i_char == ChDollar);
        o_class.is_bin_pfx = (i_char == ChPct);
        o_class.bin_ok     = (i_char == Ch0) || (i_char == Ch1);
        o_class.dec_ok     = is_dec;
        o_class.hex_ok     = is_dec || is_low || is_up;
        o_class.digit      = off[DigitW-1:0];
    end

endmodule

// ===== rtl/numeric_literal_parser.sv =====
// Top level of the streaming numeric literal parser.
// Instantiates nlp_char_dec; depends on nlp_pkg.
//
// One ASCII character enters per word on the slave stream; s_tuser marks the
// first character of a new literal. An optional leading '-' is followed by an
// optional radix prefix ('x' or '$' for hex, '%' for binary; none means
// decimal) and then digits, which build a 32-bit value that wraps modulo 2^32.
// The first character that is not a digit of the current radix ends the
// literal and produces one word on the master stream: the signed value and
// the number of characters of the literal (sign, prefix and digits, the
// ending character excluded, saturating at 255). Characters after the end
// and before the next start flag are dropped; a start flag in the middle of a
// literal drops that literal without a result. The block takes one character
// every cycle while no finished result waits on m_tready. A character passes an
// input register and then the parse state update, which loads the result
// register that drives m_tvalid; the parse state loop (sign, accumulator
// shift-add by a constant radix, count) sets that rate. While a finished result
// waits on m_tready the parse stage holds, and at most one more character is
// taken into the input register.
module numeric_literal_parser
    import nlp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] character
    input  logic        s_tuser,   // [0] start_req
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [31:0] value, [39:32] consumed
);

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_PREFIX = 3'd1,
        PH_HEX    = 3'd2,
        PH_BIN    = 3'd3,
        PH_DEC    = 3'd4
    } t_phase;

    // Input register
    logic              r_in_valid;
    logic [CharW-1:0]  r_in_char;
    logic              r_in_start;

    // Parse state
    t_phase            r_phase;
    logic              r_neg;
    logic [ValueW-1:0] r_acc;
    logic [CountW-1:0] r_cnt;

    // Result register
    logic              r_out_valid;
    logic [ValueW-1:0] r_out_value;
    logic [CountW-1:0] r_out_count;

    t_phase            n_phase;
    logic              n_neg;
    logic [ValueW-1:0] n_acc;
    logic [CountW-1:0] n_cnt;
    logic              n_emit;

    t_char_class       cls;
    logic              proc_ready;
    logic              fire;
    t_phase            base_phase;
    logic              base_neg;
    logic [ValueW-1:0] base_acc;
    logic [CountW-1:0] base_cnt;
    logic [CountW-1:0] cnt_inc;
    logic [ValueW-1:0] acc_x2;
    logic [ValueW-1:0] acc_x10;
    logic [ValueW-1:0] acc_x16;
    logic [ValueW-1:0] dig_ext;

    nlp_char_dec u_char_dec (
        .i_char  (r_in_char),
        .o_class (cls)
    );

    // The parse stage may advance unless a result is stuck in the output.
    assign proc_ready = !r_out_valid || m_tready;
    assign fire       = r_in_valid && proc_ready;
    assign s_tready   = !r_in_valid || proc_ready;

    always_comb begin
        // A start flag opens a fresh literal before the character is looked at
        base_phase = r_in_start ? PH_PREFIX : r_phase;
        base_neg   = r_in_start ? 1'b0 : r_neg;
        base_acc   = r_in_start ? '0 : r_acc;
        base_cnt   = r_in_start ? '0 : r_cnt;

        cnt_inc = (base_cnt == {CountW{1'b1}}) ? base_cnt : base_cnt + CountW'(1);
        dig_ext = {{(ValueW-DigitW){1'b0}}, cls.digit};
        acc_x2  = {base_acc[ValueW-2:0], 1'b0};
        acc_x16 = {base_acc[ValueW-5:0], 4'b0};
        acc_x10 = {base_acc[ValueW-4:0], 3'b0} + acc_x2;

        n_phase = base_phase;
        n_neg   = base_neg;
        n_acc   = base_acc;
        n_cnt   = base_cnt;
        n_emit  = 1'b0;

        if (r_in_start && cls.is_minus) begin
            n_neg = 1'b1;
            n_cnt = cnt_inc;
        end else begin
            unique case (base_phase)
                PH_PREFIX: begin
                    if (cls.is_hex_pfx) begin
                        n_cnt   = cnt_inc;
                        n_phase = PH_HEX;
                    end else if (cls.is_bin_pfx) begin
                        n_cnt   = cnt_inc;
                        n_phase = PH_BIN;
                    end else if (cls.dec_ok) begin
                        n_acc   = acc_x10 + dig_ext;
                        n_cnt   = cnt_inc;
                        n_phase = PH_DEC;
                    end else begin
                        n_emit  = 1'b1;
                        n_phase = PH_IDLE;
                    end
                end
                PH_HEX: begin
                    if (cls.hex_ok) begin
                        n_acc = acc_x16 + dig_ext;
                        n_cnt = cnt_inc;
                    end else begin
                        n_emit  = 1'b1;
                        n_phase = PH_IDLE;
                    end
                end
                PH_BIN: begin
                    if (cls.bin_ok) begin
                        n_acc = acc_x2 + dig_ext;
                        n_cnt = cnt_inc;
                    end else begin
                        n_emit  = 1'b1;
                        n_phase = PH_IDLE;
                    end
                end
                PH_DEC: begin
                    if (cls.dec_ok) begin
                        n_acc = acc_x10 + dig_ext;
                        n_cnt = cnt_inc;
                    end else begin
                        n_emit  = 1'b1;
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    // idle: drop the character
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_phase     <= PH_IDLE;
            r_neg       <= 1'b0;
            r_acc       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Capture a new character whenever the input register frees up
            if (s_tready) begin
                r_in_valid <= s_tvalid;
            end
            // Commit the parse update for the held character
            if (fire) begin
                r_phase <= n_phase;
                r_neg   <= n_neg;
                r_acc   <= n_acc;
                r_cnt   <= n_cnt;
            end
            // Load a finished literal, or drop the delivered one
            if (fire && n_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (s_tready && s_tvalid) begin
            r_in_char  <= s_tdata;
            r_in_start <= s_tuser;
        end
        if (fire && n_emit) begin
            r_out_value <= base_neg ? (ValueW'(0) - base_acc) : base_acc;
            r_out_count <= base_cnt;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {r_out_count, r_out_value};

`ifndef SYNTHESIS
    // An ending character always returns the parser to idle.
    a_emit_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && n_emit) |=> (r_phase == PH_IDLE))
        else $error("phase not idle after a literal ended");

    // With the result register empty the input side never stalls.
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> s_tready)
        else $error("input stalled with empty result register");

    // A result appears only when the parse stage committed an ending character.
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(r_out_valid) && r_out_valid) |-> $past(fire && n_emit))
        else $error("result appeared without an ending character");

    // A start flag with a minus leaves a negative literal awaiting its prefix.
    a_minus_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in_start && cls.is_minus) |=> (r_neg && r_phase == PH_PREFIX))
        else $error("leading minus not recorded");
`endif

endmodule
